[hdl/lzr_pkg.sv]
`timescale 1ns / 1ps
// Package for the ramp and run decompressor: decode phases, command kinds,
// status codes and the command record passed from the front end to the back end.
// No dependencies.
package lzr_pkg;

	localparam int OFFSET_W = 14;
	localparam int LEN_W = 9;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = 2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD_SIZE = 2'd1;
	localparam logic [1:0] ST_CORRUPT = 2'd2;
	localparam logic [1:0] ST_TRUNCATED = 2'd3;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_OPCODE,
		PH_LITERAL,
		PH_OPND1,
		PH_OPND2,
		PH_DONE
	} phase_t;

	typedef enum logic [2:0] {
		K_NONE,
		K_LIT,
		K_REP1,
		K_REP2,
		K_RAMP8,
		K_RAMP16,
		K_BREF
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [LEN_W-1:0] len;
		logic [OFFSET_W-1:0] offset;
		logic [7:0] lit;
		logic ends;
		logic [1:0] status;
	} cmd_t;

endpackage

[hdl/lzr_front.sv]
`timescale 1ns / 1ps
// Front end: takes compressed bytes, parses the header and the opcodes,
// checks every command against the declared size and pushes command records.
// Depends on lzr_pkg.
module lzr_front (
	input logic clk,
	input logic arst_n,
	input logic take,
	input logic [7:0] in_byte,
	input logic in_last,
	input logic [31:0] max_size,
	output logic push,
	output lzr_pkg::cmd_t cmd
);

	lzr_pkg::phase_t phase_q, phase_d;
	logic [1:0] hdr_idx_q, hdr_idx_d;
	logic [31:0] remain_q, remain_d;
	logic [31:0] outcnt_q, outcnt_d;
	logic [7:0] pend_op_q, pend_op_d;
	logic [7:0] pend_opnd_q, pend_opnd_d;
	logic [5:0] lit_left_q, lit_left_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lzr_pkg::PH_HEADER;
			hdr_idx_q <= '0;
			remain_q <= '0;
			outcnt_q <= '0;
			pend_op_q <= '0;
			pend_opnd_q <= '0;
			lit_left_q <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			hdr_idx_q <= hdr_idx_d;
			remain_q <= remain_d;
			outcnt_q <= outcnt_d;
			pend_op_q <= pend_op_d;
			pend_opnd_q <= pend_opnd_d;
			lit_left_q <= lit_left_d;
		end
	end

	always_comb begin
		logic end_req;
		logic [1:0] end_code;
		logic do_cmd;
		logic cmpl;
		logic do_bref;
		logic [lzr_pkg::OFFSET_W-1:0] bref_off;
		logic [lzr_pkg::LEN_W-1:0] bref_len;
		logic [31:0] size_v;
		logic [lzr_pkg::LEN_W-1:0] n;

		phase_d = phase_q;
		hdr_idx_d = hdr_idx_q;
		remain_d = remain_q;
		outcnt_d = outcnt_q;
		pend_op_d = pend_op_q;
		pend_opnd_d = pend_opnd_q;
		lit_left_d = lit_left_q;
		end_req = 1'b0;
		end_code = lzr_pkg::ST_OK;
		do_cmd = 1'b0;
		cmpl = 1'b0;
		do_bref = 1'b0;
		bref_off = '0;
		bref_len = '0;
		size_v = remain_q;
		n = '0;
		cmd = '0;
		cmd.kind = lzr_pkg::K_NONE;
		cmd.lit = in_byte;

		unique case (phase_q)
			lzr_pkg::PH_HEADER: begin
				unique case (hdr_idx_q)
					2'd0: size_v = {remain_q[31:8], in_byte};
					2'd1: size_v = {remain_q[31:16], in_byte, remain_q[7:0]};
					2'd2: size_v = {remain_q[31:24], in_byte, remain_q[15:0]};
					default: size_v = {in_byte, remain_q[23:0]};
				endcase
				remain_d = size_v;
				hdr_idx_d = hdr_idx_q + 2'd1;
				if (hdr_idx_q == 2'd3) begin
					phase_d = lzr_pkg::PH_OPCODE;
					if (in_last) begin
						end_req = 1'b1;
						end_code = lzr_pkg::ST_TRUNCATED;
					end else if (size_v == 32'd0 || size_v > max_size) begin
						end_req = 1'b1;
						end_code = lzr_pkg::ST_BAD_SIZE;
					end
				end else if (in_last) begin
					end_req = 1'b1;
					end_code = lzr_pkg::ST_TRUNCATED;
				end
			end
			lzr_pkg::PH_OPCODE: begin
				if (in_byte == 8'h00) begin
					end_req = 1'b1;
					end_code = (remain_q == 32'd0) ? lzr_pkg::ST_OK : lzr_pkg::ST_CORRUPT;
				end else if (in_byte <= 8'h3f) begin
					if ({24'd0, in_byte} > remain_q) begin
						end_req = 1'b1;
						end_code = lzr_pkg::ST_CORRUPT;
					end else begin
						lit_left_d = in_byte[5:0];
						phase_d = lzr_pkg::PH_LITERAL;
						if (in_last) begin
							end_req = 1'b1;
							end_code = lzr_pkg::ST_TRUNCATED;
						end
					end
				end else if (in_byte <= 8'h4f || (in_byte >= 8'h60 && in_byte <= 8'h6f)) begin
					n = {5'd0, in_byte[3:0]} + 9'd3;
					if (outcnt_q < ((in_byte <= 8'h4f) ? 32'd2 : 32'd1)
							|| {23'd0, n} > remain_q) begin
						end_req = 1'b1;
						end_code = lzr_pkg::ST_CORRUPT;
					end else begin
						do_cmd = 1'b1;
						cmpl = 1'b1;
						cmd.kind = (in_byte <= 8'h4f) ? lzr_pkg::K_RAMP8 : lzr_pkg::K_REP1;
						cmd.len = n;
					end
				end else if (in_byte <= 8'h7f) begin
					n = {5'd0, in_byte[3:0]} + 9'd2;
					if (outcnt_q < ((in_byte <= 8'h5f) ? 32'd4 : 32'd2)
							|| {23'd0, n} > (remain_q >> 1)) begin
						end_req = 1'b1;
						end_code = lzr_pkg::ST_CORRUPT;
					end else begin
						do_cmd = 1'b1;
						cmpl = 1'b1;
						cmd.kind = (in_byte <= 8'h5f) ? lzr_pkg::K_RAMP16 : lzr_pkg::K_REP2;
						cmd.len = {n[lzr_pkg::LEN_W-2:0], 1'b0};
					end
				end else if (in_byte <= 8'hbf) begin
					do_bref = 1'b1;
					bref_off = {8'd0, in_byte[5:0]} + 14'd3;
					bref_len = 9'd3;
				end else begin
					pend_op_d = in_byte;
					phase_d = lzr_pkg::PH_OPND1;
					if (in_last) begin
						end_req = 1'b1;
						end_code = lzr_pkg::ST_TRUNCATED;
					end
				end
			end
			lzr_pkg::PH_LITERAL: begin
				do_cmd = 1'b1;
				cmd.kind = lzr_pkg::K_LIT;
				cmd.len = 9'd1;
				lit_left_d = lit_left_q - 6'd1;
				if (lit_left_q == 6'd1) begin
					cmpl = 1'b1;
				end else if (in_last) begin
					end_req = 1'b1;
					end_code = lzr_pkg::ST_TRUNCATED;
				end
			end
			lzr_pkg::PH_OPND1: begin
				pend_opnd_d = in_byte;
				if (pend_op_q >= 8'he0) begin
					phase_d = lzr_pkg::PH_OPND2;
					if (in_last) begin
						end_req = 1'b1;
						end_code = lzr_pkg::ST_TRUNCATED;
					end
				end else begin
					phase_d = lzr_pkg::PH_OPCODE;
					do_bref = 1'b1;
					bref_off = {4'd0, pend_op_q[1:0], in_byte} + 14'd3;
					bref_len = {6'd0, pend_op_q[4:2]} + 9'd4;
				end
			end
			lzr_pkg::PH_OPND2: begin
				phase_d = lzr_pkg::PH_OPCODE;
				do_bref = 1'b1;
				bref_off = {1'b0, pend_op_q[4:0], pend_opnd_q} + 14'd3;
				bref_len = {1'b0, in_byte} + 9'd5;
			end
			default: begin
			end
		endcase

		if (do_bref) begin
			if ({18'd0, bref_off} > outcnt_q || {23'd0, bref_len} > remain_q) begin
				end_req = 1'b1;
				end_code = lzr_pkg::ST_CORRUPT;
			end else begin
				do_cmd = 1'b1;
				cmpl = 1'b1;
				cmd.kind = lzr_pkg::K_BREF;
				cmd.len = bref_len;
				cmd.offset = bref_off;
			end
		end

		if (do_cmd) begin
			outcnt_d = outcnt_q + {23'd0, cmd.len};
			remain_d = remain_q - {23'd0, cmd.len};
			if (cmpl) begin
				phase_d = lzr_pkg::PH_OPCODE;
				if (remain_q == {23'd0, cmd.len}) begin
					end_req = 1'b1;
					end_code = lzr_pkg::ST_OK;
				end else if (in_last) begin
					end_req = 1'b1;
					end_code = lzr_pkg::ST_TRUNCATED;
				end
			end
		end

		if (end_req) begin
			phase_d = lzr_pkg::PH_DONE;
			cmd.ends = 1'b1;
			cmd.status = end_code;
		end

		push = take && (do_cmd || end_req);
	end

endmodule

[hdl/lzr_fifo.sv]
`timescale 1ns / 1ps
// Short queue of command records between the front end and the back end.
// Depends on lzr_pkg.
module lzr_fifo (
	input logic clk,
	input logic arst_n,
	input logic push,
	input lzr_pkg::cmd_t wr_cmd,
	input logic pop,
	output logic full,
	output logic not_empty,
	output lzr_pkg::cmd_t rd_cmd
);

	lzr_pkg::cmd_t slots_q [lzr_pkg::QUEUE_DEPTH];
	logic [lzr_pkg::QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [lzr_pkg::QUEUE_AW:0] count_q;

	assign full = (count_q == (lzr_pkg::QUEUE_AW + 1)'(lzr_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_cmd = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hdl/lzr_back.sv]
`timescale 1ns / 1ps
// Back end: carries out command records, keeps the history window and the
// last four output bytes, and packs output bytes into results of up to eight.
// Depends on lzr_pkg.
module lzr_back #(
	parameter int WINDOW_DEPTH = 16384
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input lzr_pkg::cmd_t cmd,
	output logic cmd_pop,
	output logic out_valid,
	input logic out_ready,
	output logic [63:0] out_bytes,
	output logic [3:0] byte_count,
	output logic run_last,
	output logic stream_end,
	output logic [1:0] status
);

	localparam int AW = $clog2(WINDOW_DEPTH);

	logic [7:0] mem [WINDOW_DEPTH];
	logic [7:0] rd_data_q;
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_addr;
	logic [AW+1:0] ra_sum;
	logic loaded_q;
	logic [lzr_pkg::LEN_W-1:0] rem_q;
	logic rd_pend_q;
	logic [63:0] acc_q;
	logic [3:0] acc_cnt_q;
	logic [7:0] t1_q, t2_q, t3_q, t4_q, hi_q;
	logic out_valid_q;
	logic [63:0] out_bytes_q;
	logic [3:0] byte_count_q;
	logic run_last_q, stream_end_q;
	logic [1:0] status_q;

	logic out_free, can_emit, issue, emit, flush_mid, flush_fin;
	logic [7:0] emit_byte;
	logic [15:0] nw;

	assign out_free = !out_valid_q || out_ready;
	assign can_emit = loaded_q && (rem_q != '0) && (acc_cnt_q != 4'd8);
	assign issue = can_emit && (cmd.kind == lzr_pkg::K_BREF) && !rd_pend_q;
	assign emit = (cmd.kind == lzr_pkg::K_BREF) ? rd_pend_q : can_emit;
	assign flush_mid = loaded_q && (acc_cnt_q == 4'd8) && (rem_q != '0) && out_free;
	assign flush_fin = loaded_q && (rem_q == '0) && out_free;
	assign cmd_pop = flush_fin;

	assign ra_sum = (AW + 2)'(wr_ptr_q) + (AW + 2)'(WINDOW_DEPTH)
		- (AW + 2)'(cmd.offset);
	assign rd_addr = (ra_sum >= (AW + 2)'(WINDOW_DEPTH))
		? AW'(ra_sum - (AW + 2)'(WINDOW_DEPTH)) : AW'(ra_sum);

	assign nw = ({t1_q, t2_q} << 1) - {t3_q, t4_q};

	always_comb begin
		case (cmd.kind)
			lzr_pkg::K_LIT: emit_byte = cmd.lit;
			lzr_pkg::K_REP1: emit_byte = t1_q;
			lzr_pkg::K_REP2: emit_byte = t2_q;
			lzr_pkg::K_RAMP8: emit_byte = (t1_q << 1) - t2_q;
			lzr_pkg::K_RAMP16: emit_byte = rem_q[0] ? hi_q : nw[7:0];
			lzr_pkg::K_BREF: emit_byte = rd_data_q;
			default: emit_byte = 8'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			mem[wr_ptr_q] <= emit_byte;
		end
		if (issue) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			t1_q <= emit_byte;
			t2_q <= t1_q;
			t3_q <= t2_q;
			t4_q <= t3_q;
			if (cmd.kind == lzr_pkg::K_RAMP16 && !rem_q[0]) begin
				hi_q <= nw[15:8];
			end
		end
		if (flush_mid || flush_fin) begin
			out_bytes_q <= acc_q;
			byte_count_q <= acc_cnt_q;
			run_last_q <= flush_fin;
			stream_end_q <= flush_fin && cmd.ends;
			status_q <= (flush_fin && cmd.ends) ? cmd.status : lzr_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			loaded_q <= 1'b0;
			rem_q <= '0;
			rd_pend_q <= 1'b0;
			acc_q <= '0;
			acc_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (!loaded_q && cmd_valid) begin
				loaded_q <= 1'b1;
				rem_q <= cmd.len;
			end
			if (issue) begin
				rd_pend_q <= 1'b1;
			end
			if (emit) begin
				rd_pend_q <= 1'b0;
				rem_q <= rem_q - 1'b1;
				acc_q[acc_cnt_q[2:0]*8 +: 8] <= emit_byte;
				acc_cnt_q <= acc_cnt_q + 4'd1;
				wr_ptr_q <= (wr_ptr_q == AW'(WINDOW_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (flush_mid || flush_fin) begin
				acc_q <= '0;
				acc_cnt_q <= '0;
				out_valid_q <= (acc_cnt_q != 4'd0) || cmd.ends;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (flush_fin) begin
				loaded_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_bytes = out_bytes_q;
	assign byte_count = byte_count_q;
	assign run_last = run_last_q;
	assign stream_end = stream_end_q;
	assign status = status_q;

endmodule

[hdl/lz_ramp_run_decompressor.sv]
`timescale 1ns / 1ps
// Each compressed byte is one transaction on the input channel; the front end
// takes it whenever its four-entry command queue has room. The back end loads
// each command, then writes its output bytes one at a time: literals, ramps and
// repeats directly, back references after a read of the history window, which
// is a single-port memory with a registered read, so that the next byte of a
// copy is read only once the last one is written. Each result of up to eight
// bytes is handed over when the output register is free. The input stalls only
// while the queue is full. The history window needs no clearing pass.
// Depends on lzr_pkg, lzr_front, lzr_fifo and lzr_back.
module lz_ramp_run_decompressor #(
	parameter int WINDOW_DEPTH = 16384
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [31:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] in_byte,
	input logic in_last,
	output logic out_valid,
	input logic out_ready,
	output logic [63:0] out_bytes,
	output logic [3:0] byte_count,
	output logic run_last,
	output logic stream_end,
	output logic [1:0] status
);

	logic [31:0] max_size_q;
	logic q_full, q_not_empty, push, pop;
	lzr_pkg::cmd_t wr_cmd, rd_cmd;

	assign cfg_ready = 1'b1;
	assign in_ready = !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_size_q <= 32'd16777216;
		end else if (cfg_valid) begin
			max_size_q <= cfg_data;
		end
	end

	lzr_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.take(in_valid && in_ready),
		.in_byte(in_byte),
		.in_last(in_last),
		.max_size(max_size_q),
		.push(push),
		.cmd(wr_cmd)
	);

	lzr_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_cmd(wr_cmd),
		.pop(pop),
		.full(q_full),
		.not_empty(q_not_empty),
		.rd_cmd(rd_cmd)
	);

	lzr_back #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(q_not_empty),
		.cmd(rd_cmd),
		.cmd_pop(pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_bytes(out_bytes),
		.byte_count(byte_count),
		.run_last(run_last),
		.stream_end(stream_end),
		.status(status)
	);

endmodule
